// ===== sv/hfsc_pkg.sv =====
package hfsc_pkg;

  // Window length and sample range.
  localparam int SAMPLES_PER_WINDOW = 20;
  localparam int SAMPLE_W           = 10;
  localparam int SAMPLE_MAX         = (1 << SAMPLE_W) - 1;

  // Accumulator width covers a full window of maximum samples.
  localparam int ACC_W = $clog2(SAMPLES_PER_WINDOW * SAMPLE_MAX + 1);
  localparam int CNT_W = (SAMPLES_PER_WINDOW > 1) ? $clog2(SAMPLES_PER_WINDOW) : 1;

  // Floored division by the window length as a multiply by a rounded-up
  // reciprocal. With this shift the result is exact for every sum below 2**ACC_W.
  localparam int RECIP_SHIFT = ACC_W + $clog2(SAMPLES_PER_WINDOW);
  localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + SAMPLES_PER_WINDOW - 1)
                               / SAMPLES_PER_WINDOW;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = ACC_W + RECIP_W;

  // Temperature in 1/1024 degree C.
  localparam int TEMP_W     = 19;
  localparam int TEMP_SCALE = 500;
  localparam int FRAC_W     = 10;

  localparam int GAS_W  = 10;
  localparam int DUTY_W = 8;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LOW_THRESHOLD   = 3'd0,
    REG_HIGH_THRESHOLD  = 3'd1,
    REG_HYSTERESIS_BAND = 3'd2,
    REG_GAS_THRESHOLD   = 3'd3,
    REG_DUTY_MEDIUM     = 3'd4,
    REG_DUTY_MAX        = 3'd5
  } cfg_reg_e;

  localparam logic [TEMP_W-1:0] LOW_THRESH_RST  = TEMP_W'(33792);
  localparam logic [TEMP_W-1:0] HIGH_THRESH_RST = TEMP_W'(38912);
  localparam logic [TEMP_W-1:0] HYST_RST        = TEMP_W'(2048);
  localparam logic [GAS_W-1:0]  GAS_THRESH_RST  = GAS_W'(130);
  localparam logic [DUTY_W-1:0] DUTY_MED_RST    = DUTY_W'(150);
  localparam logic [DUTY_W-1:0] DUTY_MAX_RST    = DUTY_W'(255);

  // Temperature modes as a one-hot state register.
  typedef enum logic [2:0] {
    MODE_OFF    = 3'b001,
    MODE_MEDIUM = 3'b010,
    MODE_HIGH   = 3'b100
  } mode_e;

  // Encoded mode and LED values on the result word.
  localparam logic [1:0] MODE_CODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_CODE_MEDIUM = 2'd1;
  localparam logic [1:0] MODE_CODE_HIGH   = 2'd2;

  localparam logic [1:0] LED_GREEN  = 2'd0;
  localparam logic [1:0] LED_YELLOW = 2'd1;
  localparam logic [1:0] LED_RED    = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] temp_sample;
    logic [SAMPLE_W-1:0] gas_sample;
    logic                gas_pin_level;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] fan_duty;
    logic [1:0]        led_select;
    logic              gas_alarm;
    logic [1:0]        fan_mode;
    logic [8:0]        temp_whole;
    logic [3:0]        temp_tenth;
    logic [GAS_W-1:0]  gas_average;
  } out_item_t;

  typedef struct packed {
    logic [TEMP_W-1:0] low_threshold;
    logic [TEMP_W-1:0] high_threshold;
    logic [TEMP_W-1:0] hysteresis_band;
    logic [GAS_W-1:0]  gas_threshold;
    logic [DUTY_W-1:0] duty_medium;
    logic [DUTY_W-1:0] duty_max;
  } cfg_t;

  // Switching points of the hysteresis machine. A lower point that would
  // fall below zero is disabled.
  typedef struct packed {
    logic [TEMP_W:0]   up_medium;
    logic [TEMP_W-1:0] down_off;
    logic              down_off_en;
    logic [TEMP_W:0]   up_high;
    logic [TEMP_W-1:0] down_medium;
    logic              down_medium_en;
  } limits_t;

  // A completed window on its way through the pipeline.
  typedef struct packed {
    logic [ACC_W-1:0] temp_sum;
    logic [ACC_W-1:0] gas_sum;
    logic             pin_level;
  } window_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_value;
    logic [GAS_W-1:0]  gas_average;
    logic              gas_alarm;
  } scaled_t;

endpackage

// ===== sv/hfsc_cfg.sv =====
module hfsc_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [2:0]      cfg_index_i,
  input  logic [18:0]     cfg_data_i,
  output hfsc_pkg::cfg_t    cfg_o,
  output hfsc_pkg::limits_t limits_o
);
  import hfsc_pkg::*;

  cfg_t    cfg_q, cfg_d;
  limits_t limits_q, limits_d;
  logic [TEMP_W:0] lo_diff, hi_diff;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LOW_THRESHOLD:   cfg_d.low_threshold   = cfg_data_i[TEMP_W-1:0];
        REG_HIGH_THRESHOLD:  cfg_d.high_threshold  = cfg_data_i[TEMP_W-1:0];
        REG_HYSTERESIS_BAND: cfg_d.hysteresis_band = cfg_data_i[TEMP_W-1:0];
        REG_GAS_THRESHOLD:   cfg_d.gas_threshold   = cfg_data_i[GAS_W-1:0];
        REG_DUTY_MEDIUM:     cfg_d.duty_medium     = cfg_data_i[DUTY_W-1:0];
        REG_DUTY_MAX:        cfg_d.duty_max        = cfg_data_i[DUTY_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  // The switching points follow the registers in the next cycle.
  always_comb begin
    lo_diff = {1'b0, cfg_q.low_threshold} - {1'b0, cfg_q.hysteresis_band};
    hi_diff = {1'b0, cfg_q.high_threshold} - {1'b0, cfg_q.hysteresis_band};
    limits_d.up_medium      = {1'b0, cfg_q.low_threshold} + {1'b0, cfg_q.hysteresis_band};
    limits_d.up_high        = {1'b0, cfg_q.high_threshold} + {1'b0, cfg_q.hysteresis_band};
    limits_d.down_off       = lo_diff[TEMP_W-1:0];
    limits_d.down_off_en    = ~lo_diff[TEMP_W];
    limits_d.down_medium    = hi_diff[TEMP_W-1:0];
    limits_d.down_medium_en = ~hi_diff[TEMP_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold     <= LOW_THRESH_RST;
      cfg_q.high_threshold    <= HIGH_THRESH_RST;
      cfg_q.hysteresis_band   <= HYST_RST;
      cfg_q.gas_threshold     <= GAS_THRESH_RST;
      cfg_q.duty_medium       <= DUTY_MED_RST;
      cfg_q.duty_max          <= DUTY_MAX_RST;
      limits_q.up_medium      <= {1'b0, LOW_THRESH_RST} + {1'b0, HYST_RST};
      limits_q.up_high        <= {1'b0, HIGH_THRESH_RST} + {1'b0, HYST_RST};
      limits_q.down_off       <= LOW_THRESH_RST - HYST_RST;
      limits_q.down_off_en    <= (LOW_THRESH_RST >= HYST_RST);
      limits_q.down_medium    <= HIGH_THRESH_RST - HYST_RST;
      limits_q.down_medium_en <= (HIGH_THRESH_RST >= HYST_RST);
    end else begin
      cfg_q    <= cfg_d;
      limits_q <= limits_d;
    end
  end

  assign cfg_o    = cfg_q;
  assign limits_o = limits_q;

endmodule

// ===== sv/hfsc_accum.sv =====
module hfsc_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  hfsc_pkg::in_item_t in_data_i,
  input  logic               win_ready_i,
  output logic               win_valid_o,
  output hfsc_pkg::window_t  win_o
);
  import hfsc_pkg::*;

  logic [ACC_W-1:0] temp_acc_q, temp_acc_d, gas_acc_q, gas_acc_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             win_valid_q, win_valid_d;
  window_t          win_q;
  logic [ACC_W-1:0] temp_sum, gas_sum;
  logic             last_item;

  assign temp_sum  = temp_acc_q + ACC_W'(in_data_i.temp_sample);
  assign gas_sum   = gas_acc_q + ACC_W'(in_data_i.gas_sample);
  assign last_item = (count_q == CNT_W'(SAMPLES_PER_WINDOW - 1));

  always_comb begin
    temp_acc_d  = temp_acc_q;
    gas_acc_d   = gas_acc_q;
    count_d     = count_q;
    win_valid_d = win_valid_q && !win_ready_i;
    if (accept_i) begin
      if (last_item) begin
        temp_acc_d  = '0;
        gas_acc_d   = '0;
        count_d     = '0;
        win_valid_d = 1'b1;
      end else begin
        temp_acc_d = temp_sum;
        gas_acc_d  = gas_sum;
        count_d    = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_acc_q  <= '0;
      gas_acc_q   <= '0;
      count_q     <= '0;
      win_valid_q <= 1'b0;
    end else begin
      temp_acc_q  <= temp_acc_d;
      gas_acc_q   <= gas_acc_d;
      count_q     <= count_d;
      win_valid_q <= win_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && last_item) begin
      win_q.temp_sum  <= temp_sum;
      win_q.gas_sum   <= gas_sum;
      win_q.pin_level <= in_data_i.gas_pin_level;
    end
  end

  assign win_valid_o = win_valid_q;
  assign win_o       = win_q;

endmodule

// ===== sv/hfsc_scale.sv =====
module hfsc_scale (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     win_valid_i,
  input  hfsc_pkg::window_t        win_i,
  output logic                     win_ready_o,
  input  logic [hfsc_pkg::GAS_W-1:0] gas_threshold_i,
  input  logic                     next_ready_i,
  output logic                     scaled_valid_o,
  output hfsc_pkg::scaled_t        scaled_o
);
  import hfsc_pkg::*;

  localparam logic [PROD_W-1:0] RecipC = PROD_W'(RECIP_MULT);

  logic [PROD_W-1:0]   temp_prod, gas_prod;
  logic [SAMPLE_W-1:0] temp_avg_q, gas_avg_q;
  logic                pin_q;
  logic                avg_valid_q, scaled_valid_q;
  logic                avg_free, scaled_free;
  scaled_t             scaled_q;

  assign scaled_free = !scaled_valid_q || next_ready_i;
  assign avg_free    = !avg_valid_q || scaled_free;
  assign win_ready_o = avg_free;

  // First stage: floored averages by reciprocal multiply.
  assign temp_prod = PROD_W'(win_i.temp_sum) * RecipC;
  assign gas_prod  = PROD_W'(win_i.gas_sum) * RecipC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_valid_q    <= 1'b0;
      scaled_valid_q <= 1'b0;
    end else begin
      if (avg_free) begin
        avg_valid_q <= win_valid_i;
      end
      if (scaled_free) begin
        scaled_valid_q <= avg_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (avg_free && win_valid_i) begin
      temp_avg_q <= temp_prod[RECIP_SHIFT +: SAMPLE_W];
      gas_avg_q  <= gas_prod[RECIP_SHIFT +: SAMPLE_W];
      pin_q      <= win_i.pin_level;
    end
    // Second stage: scale to 1/1024 degree C and decide the gas alarm.
    if (scaled_free && avg_valid_q) begin
      scaled_q.temp_value  <= TEMP_W'(temp_avg_q) * TEMP_W'(TEMP_SCALE);
      scaled_q.gas_average <= gas_avg_q;
      scaled_q.gas_alarm   <= !pin_q || (gas_avg_q > gas_threshold_i);
    end
  end

  assign scaled_valid_o = scaled_valid_q;
  assign scaled_o       = scaled_q;

endmodule

// ===== sv/hfsc_ctrl.sv =====
module hfsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                scaled_valid_i,
  input  hfsc_pkg::scaled_t   scaled_i,
  output logic                ready_o,
  input  hfsc_pkg::cfg_t      cfg_i,
  input  hfsc_pkg::limits_t   limits_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output hfsc_pkg::out_item_t out_data_o
);
  import hfsc_pkg::*;

  logic [TEMP_W-1:0]   smooth_q, smooth_d;
  logic                smooth_valid_q;
  mode_e               mode_q, mode_d;
  logic                out_valid_q;
  out_item_t           out_q, out_d;
  logic [TEMP_W:0]     smooth_sum;
  logic [FRAC_W+3:0]   frac_x10;
  logic                load;

  assign ready_o = !out_valid_q || !out_stall_i;
  assign load    = ready_o && scaled_valid_i;

  // The first window loads the smoothed value directly; later ones take the
  // floored mean of old and new.
  always_comb begin
    smooth_sum = {1'b0, smooth_q} + {1'b0, scaled_i.temp_value};
    smooth_d   = smooth_valid_q ? smooth_sum[TEMP_W:1] : scaled_i.temp_value;
  end

  // Hysteresis machine; an alarm holds the current mode.
  always_comb begin
    mode_d = mode_q;
    if (!scaled_i.gas_alarm) begin
      unique case (mode_q)
        MODE_OFF: begin
          if ({1'b0, smooth_d} > limits_i.up_medium) mode_d = MODE_MEDIUM;
        end
        MODE_MEDIUM: begin
          if (limits_i.down_off_en && (smooth_d < limits_i.down_off)) begin
            mode_d = MODE_OFF;
          end else if ({1'b0, smooth_d} > limits_i.up_high) begin
            mode_d = MODE_HIGH;
          end
        end
        MODE_HIGH: begin
          if (limits_i.down_medium_en && (smooth_d < limits_i.down_medium)) begin
            mode_d = MODE_MEDIUM;
          end
        end
        default: mode_d = MODE_OFF;
      endcase
    end
  end

  // Tenths digit: ten times the fraction, scaled back by 1/1024.
  assign frac_x10 = {1'b0, smooth_d[FRAC_W-1:0], 3'b000} +
                    {3'b000, smooth_d[FRAC_W-1:0], 1'b0};

  always_comb begin
    out_d.gas_alarm   = scaled_i.gas_alarm;
    out_d.gas_average = scaled_i.gas_average;
    out_d.temp_whole  = smooth_d[TEMP_W-1:FRAC_W];
    out_d.temp_tenth  = frac_x10[FRAC_W+3:FRAC_W];
    unique case (mode_d)
      MODE_MEDIUM: out_d.fan_mode = MODE_CODE_MEDIUM;
      MODE_HIGH:   out_d.fan_mode = MODE_CODE_HIGH;
      default:     out_d.fan_mode = MODE_CODE_OFF;
    endcase
    if (scaled_i.gas_alarm) begin
      out_d.fan_duty   = cfg_i.duty_max;
      out_d.led_select = LED_RED;
    end else begin
      unique case (mode_d)
        MODE_MEDIUM: begin
          out_d.fan_duty   = cfg_i.duty_medium;
          out_d.led_select = LED_YELLOW;
        end
        MODE_HIGH: begin
          out_d.fan_duty   = cfg_i.duty_max;
          out_d.led_select = LED_RED;
        end
        default: begin
          out_d.fan_duty   = '0;
          out_d.led_select = LED_GREEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q       <= '0;
      smooth_valid_q <= 1'b0;
      mode_q         <= MODE_OFF;
      out_valid_q    <= 1'b0;
    end else begin
      if (ready_o) begin
        out_valid_q <= scaled_valid_i;
      end
      if (load) begin
        smooth_q       <= smooth_d;
        smooth_valid_q <= 1'b1;
        mode_q         <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/hysteresis_fan_speed_controller.sv =====
// Channel  Direction  Handshake                 Word
// in       input      in_valid_i / in_stall_o    temp_sample, gas_sample, gas_pin_level
// out      output     out_valid_o / out_stall_i  duty, LED, alarm, mode, temperature, gas
// cfg      input      cfg_valid_i / cfg_ready_o  register index and write data
//
// One input word is taken every cycle unless the input stalls. Words are
// summed in the accumulator; the last word of a window produces one result
// word that passes the window register, average multiply, temperature
// scaling and result register. Reset clears the sums, the smoothed
// temperature and the mode, and loads the register defaults; there is no
// clearing pass. A stall on the output fills the three stages behind the
// result register before the input stalls; configuration writes are taken in every cycle.
module hysteresis_fan_speed_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hfsc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hfsc_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [18:0]         cfg_data_i
);
  import hfsc_pkg::*;

  cfg_t    cfg;
  limits_t limits;
  window_t win;
  scaled_t scaled;
  logic    win_valid, win_ready;
  logic    scaled_valid, ctrl_ready;
  logic    in_accept;

  // Registers are always writable.
  assign cfg_ready_o = 1'b1;

  // Only a completed window waiting in front of a full pipeline holds off
  // the input.
  assign in_stall_o = win_valid && !win_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  hfsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .limits_o    (limits)
  );

  hfsc_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .in_data_i   (in_data_i),
    .win_ready_i (win_ready),
    .win_valid_o (win_valid),
    .win_o       (win)
  );

  hfsc_scale u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .win_valid_i     (win_valid),
    .win_i           (win),
    .win_ready_o     (win_ready),
    .gas_threshold_i (cfg.gas_threshold),
    .next_ready_i    (ctrl_ready),
    .scaled_valid_o  (scaled_valid),
    .scaled_o        (scaled)
  );

  hfsc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .scaled_valid_i (scaled_valid),
    .scaled_i       (scaled),
    .ready_o        (ctrl_ready),
    .cfg_i          (cfg),
    .limits_i       (limits),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_data_o     (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // An alarm always lights the red LED and drives the maximum duty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.gas_alarm |->
      out_data_o.led_select == LED_RED && out_data_o.fan_duty == cfg.duty_max)
    else $error("gas alarm without red LED and maximum duty");

  // Without an alarm the LED follows the reported mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.gas_alarm |->
      (out_data_o.fan_mode == MODE_CODE_OFF && out_data_o.led_select == LED_GREEN &&
       out_data_o.fan_duty == '0) ||
      (out_data_o.fan_mode == MODE_CODE_MEDIUM && out_data_o.led_select == LED_YELLOW) ||
      (out_data_o.fan_mode == MODE_CODE_HIGH && out_data_o.led_select == LED_RED))
    else $error("LED or duty does not match fan mode");

  // The tenths digit is a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.temp_tenth <= 4'd9)
    else $error("tenths digit out of range");
`endif

endmodule
